@@ design/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants for the escape-time block
// fixed-point formats, configuration indexes, coordinate and view records
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int OFFSET_W  = 32;
    localparam int ZOOM_W    = 31;
    localparam int DIM_W     = 13;
    localparam int IDX_W     = 12;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SPAN_W = DIM_W + ZOOM_W;
    localparam int POS_W  = IDX_W + ZOOM_W;
    localparam int C_W    = SPAN_W + 2;
    localparam int Z_W    = C_W + 1;
    localparam int SQ_W   = FRAC_BITS + 2;
    localparam int PROD_W = 2 * SQ_W;
    localparam int MAG_W  = PROD_W - FRAC_BITS;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // items held at most: mapper stage, queue, iteration engine
    localparam int MAX_IN_FLIGHT = FIFO_DEPTH + 2;

    localparam logic signed [Z_W-1:0] Z_TWO     = Z_W'(2) << FRAC_BITS;
    localparam logic signed [Z_W-1:0] Z_NEG_TWO = -Z_TWO;
    localparam logic [MAG_W:0]        MAG_FOUR  = (MAG_W + 1)'(4) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] CROSS_BIAS =
        (PROD_W'(1) << (FRAC_BITS - 1)) - PROD_W'(1);

    localparam logic [OFFSET_W-1:0] RST_OFFSET_X     = 32'd0;
    localparam logic [OFFSET_W-1:0] RST_OFFSET_Y     = 32'd0;
    localparam logic [ZOOM_W-1:0]   RST_ZOOM         = 31'd1048576;
    localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd1024;
    localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd1024;
    localparam logic [COUNT_W-1:0]  RST_ITER_CAP     = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X     = 3'd0,
        CFG_OFFSET_Y     = 3'd1,
        CFG_ZOOM         = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4,
        CFG_ITER_CAP     = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        IT_IDLE,
        IT_MUL,
        IT_UPD,
        IT_OUT
    } iter_state_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset_x;
        logic signed [OFFSET_W-1:0] offset_y;
        logic [ZOOM_W-1:0]          zoom;
        logic [DIM_W-1:0]           frame_width;
        logic [DIM_W-1:0]           frame_height;
    } view_t;

    typedef struct packed {
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
    } point_t;

endpackage

@@ design/mbe_map.sv @@
// ----------------------------------------------------------------------------
// mbe_map: pixel to complex-plane mapper
// registers span and position products, then forms c for the queue
// ----------------------------------------------------------------------------
module mbe_map (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbe_pkg::view_t              view,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mbe_pkg::IDX_W-1:0]   pixel_x,
    input  logic [mbe_pkg::IDX_W-1:0]   pixel_y,
    output logic                        point_valid,
    input  logic                        point_ready,
    output mbe_pkg::point_t             point
);

    logic                         s1_valid_reg;
    logic [mbe_pkg::SPAN_W-1:0]   span_x_reg;
    logic [mbe_pkg::SPAN_W-1:0]   span_y_reg;
    logic [mbe_pkg::POS_W-1:0]    pos_x_reg;
    logic [mbe_pkg::POS_W-1:0]    pos_y_reg;
    logic                         advance;
    logic [mbe_pkg::C_W-1:0]      cr_sum;
    logic [mbe_pkg::C_W-1:0]      ci_sum;

    assign advance     = !s1_valid_reg || point_ready;
    assign in_ready    = advance;
    assign point_valid = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            span_x_reg <= mbe_pkg::SPAN_W'(view.frame_width) * mbe_pkg::SPAN_W'(view.zoom);
            span_y_reg <= mbe_pkg::SPAN_W'(view.frame_height) * mbe_pkg::SPAN_W'(view.zoom);
            pos_x_reg  <= mbe_pkg::POS_W'(pixel_x) * mbe_pkg::POS_W'(view.zoom);
            pos_y_reg  <= mbe_pkg::POS_W'(pixel_y) * mbe_pkg::POS_W'(view.zoom);
        end
    end

    // c = offset - floor(dim * zoom / 2) + index * zoom
    always_comb
    begin
        cr_sum = {{(mbe_pkg::C_W - mbe_pkg::OFFSET_W){view.offset_x[mbe_pkg::OFFSET_W-1]}},
                  view.offset_x}
               - {{(mbe_pkg::C_W - mbe_pkg::SPAN_W){1'b0}}, span_x_reg >> 1}
               + {{(mbe_pkg::C_W - mbe_pkg::POS_W){1'b0}}, pos_x_reg};
        ci_sum = {{(mbe_pkg::C_W - mbe_pkg::OFFSET_W){view.offset_y[mbe_pkg::OFFSET_W-1]}},
                  view.offset_y}
               - {{(mbe_pkg::C_W - mbe_pkg::SPAN_W){1'b0}}, span_y_reg >> 1}
               + {{(mbe_pkg::C_W - mbe_pkg::POS_W){1'b0}}, pos_y_reg};
        point.cr = $signed(cr_sum);
        point.ci = $signed(ci_sum);
    end

endmodule

@@ design/mbe_fifo.sv @@
// ----------------------------------------------------------------------------
// mbe_fifo: short point queue between mapper and iteration engine
// show-ahead register queue, lets either side stall on its own
// ----------------------------------------------------------------------------
module mbe_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mbe_pkg::point_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mbe_pkg::point_t pop_data
);

    mbe_pkg::point_t                 mem [mbe_pkg::FIFO_DEPTH];
    logic [mbe_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [mbe_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [mbe_pkg::FIFO_CNT_W-1:0]  fill_reg;
    logic                            push;
    logic                            pop;

    assign push_ready = fill_reg != mbe_pkg::FIFO_CNT_W'(mbe_pkg::FIFO_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mbe_pkg::FIFO_AW'(mbe_pkg::FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mbe_pkg::FIFO_AW'(mbe_pkg::FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/mbe_iter.sv @@
// ----------------------------------------------------------------------------
// mbe_iter: escape-time iteration engine
// per iteration: square and cross products in the multiply state, then test and update
// ----------------------------------------------------------------------------
module mbe_iter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  mbe_pkg::point_t               point,
    input  logic [mbe_pkg::COUNT_W-1:0]   iter_cap,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mbe_pkg::COUNT_W-1:0]   iteration_count
);

    mbe_pkg::iter_state_t                state_reg;
    mbe_pkg::iter_state_t                state_next;
    logic [mbe_pkg::COUNT_W-1:0]         count_reg;
    logic [mbe_pkg::COUNT_W-1:0]         count_next;
    logic signed [mbe_pkg::C_W-1:0]      cr_reg;
    logic signed [mbe_pkg::C_W-1:0]      cr_next;
    logic signed [mbe_pkg::C_W-1:0]      ci_reg;
    logic signed [mbe_pkg::C_W-1:0]      ci_next;
    logic signed [mbe_pkg::Z_W-1:0]      zr_reg;
    logic signed [mbe_pkg::Z_W-1:0]      zr_next;
    logic signed [mbe_pkg::Z_W-1:0]      zi_reg;
    logic signed [mbe_pkg::Z_W-1:0]      zi_next;
    logic signed [mbe_pkg::PROD_W-1:0]   prod_rr_reg;
    logic signed [mbe_pkg::PROD_W-1:0]   prod_rr_next;
    logic signed [mbe_pkg::PROD_W-1:0]   prod_ii_reg;
    logic signed [mbe_pkg::PROD_W-1:0]   prod_ii_next;
    logic signed [mbe_pkg::PROD_W-1:0]   prod_ri_reg;
    logic signed [mbe_pkg::PROD_W-1:0]   prod_ri_next;

    logic                                in_box;
    logic signed [mbe_pkg::SQ_W-1:0]     sq_r;
    logic signed [mbe_pkg::SQ_W-1:0]     sq_i;
    logic [mbe_pkg::MAG_W-1:0]           r2;
    logic [mbe_pkg::MAG_W-1:0]           i2;
    logic [mbe_pkg::MAG_W:0]             mag;
    logic signed [mbe_pkg::PROD_W-1:0]   cross_bias;
    logic signed [mbe_pkg::PROD_W-1:0]   cross_full;

    assign pop_ready       = state_reg == mbe_pkg::IT_IDLE;
    assign out_valid       = state_reg == mbe_pkg::IT_OUT;
    assign iteration_count = count_reg;

    // datapath terms
    always_comb
    begin
        in_box = (zr_reg < mbe_pkg::Z_TWO) && (zr_reg > mbe_pkg::Z_NEG_TWO)
              && (zi_reg < mbe_pkg::Z_TWO) && (zi_reg > mbe_pkg::Z_NEG_TWO);
        sq_r   = $signed(zr_reg[mbe_pkg::SQ_W-1:0]);
        sq_i   = $signed(zi_reg[mbe_pkg::SQ_W-1:0]);
        r2     = prod_rr_reg[mbe_pkg::PROD_W-1:mbe_pkg::FRAC_BITS];
        i2     = prod_ii_reg[mbe_pkg::PROD_W-1:mbe_pkg::FRAC_BITS];
        mag    = {1'b0, r2} + {1'b0, i2};
        // 2*zr*zi, truncated toward zero
        cross_bias = prod_ri_reg[mbe_pkg::PROD_W-1] ? mbe_pkg::CROSS_BIAS : '0;
        cross_full = (prod_ri_reg + cross_bias) >>> (mbe_pkg::FRAC_BITS - 1);
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        cr_next      = cr_reg;
        ci_next      = ci_reg;
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        prod_rr_next = prod_rr_reg;
        prod_ii_next = prod_ii_reg;
        prod_ri_next = prod_ri_reg;
        case (state_reg)
            mbe_pkg::IT_IDLE:
            begin
                if (pop_valid)
                begin
                    cr_next    = point.cr;
                    ci_next    = point.ci;
                    zr_next    = mbe_pkg::Z_W'(point.cr);
                    zi_next    = mbe_pkg::Z_W'(point.ci);
                    count_next = '0;
                    state_next = mbe_pkg::IT_MUL;
                end
            end
            mbe_pkg::IT_MUL:
            begin
                if ((count_reg >= iter_cap) || !in_box)
                begin
                    state_next = mbe_pkg::IT_OUT;
                end
                else
                begin
                    prod_rr_next = sq_r * sq_r;
                    prod_ii_next = sq_i * sq_i;
                    prod_ri_next = sq_r * sq_i;
                    state_next   = mbe_pkg::IT_UPD;
                end
            end
            mbe_pkg::IT_UPD:
            begin
                if (mag >= mbe_pkg::MAG_FOUR)
                begin
                    state_next = mbe_pkg::IT_OUT;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    zr_next    = $signed({{(mbe_pkg::Z_W - mbe_pkg::MAG_W){1'b0}}, r2})
                               - $signed({{(mbe_pkg::Z_W - mbe_pkg::MAG_W){1'b0}}, i2})
                               + mbe_pkg::Z_W'(cr_reg);
                    zi_next    = mbe_pkg::Z_W'(cross_full) + mbe_pkg::Z_W'(ci_reg);
                    state_next = mbe_pkg::IT_MUL;
                end
            end
            mbe_pkg::IT_OUT:
            begin
                if (out_ready)
                begin
                    state_next = mbe_pkg::IT_IDLE;
                end
            end
            default:
            begin
                state_next = mbe_pkg::IT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbe_pkg::IT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        cr_reg      <= cr_next;
        ci_reg      <= ci_next;
        zr_reg      <= zr_next;
        zi_reg      <= zi_next;
        prod_rr_reg <= prod_rr_next;
        prod_ii_reg <= prod_ii_next;
        prod_ri_reg <= prod_ri_next;
    end

endmodule

@@ design/mandelbrot_escape_time.sv @@
// path: the registered mapper stage and the point queue, then the iteration engine, which loads a
//   point, runs a multiply and an update state per iteration and holds the count in an output state
// the single iteration engine takes one pixel at a time; the mapper and a
//   2-entry queue accept ahead meanwhile
// reset: rst_n clears the pipeline and queue and loads the default view
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time counter for one pixel
// configuration registers, pixel mapper, point queue and iteration engine
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mbe_pkg::IDX_W-1:0]         pixel_x,
    input  logic [mbe_pkg::IDX_W-1:0]         pixel_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mbe_pkg::COUNT_W-1:0]       iteration_count
);

    logic [mbe_pkg::OFFSET_W-1:0]  offset_x_reg;
    logic [mbe_pkg::OFFSET_W-1:0]  offset_y_reg;
    logic [mbe_pkg::ZOOM_W-1:0]    zoom_reg;
    logic [mbe_pkg::DIM_W-1:0]     frame_width_reg;
    logic [mbe_pkg::DIM_W-1:0]     frame_height_reg;
    logic [mbe_pkg::COUNT_W-1:0]   iter_cap_reg;

    mbe_pkg::view_t   view;
    logic             map_valid;
    logic             map_ready;
    mbe_pkg::point_t  map_point;
    logic             q_valid;
    logic             q_ready;
    mbe_pkg::point_t  q_point;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg     <= mbe_pkg::RST_OFFSET_X;
            offset_y_reg     <= mbe_pkg::RST_OFFSET_Y;
            zoom_reg         <= mbe_pkg::RST_ZOOM;
            frame_width_reg  <= mbe_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= mbe_pkg::RST_FRAME_HEIGHT;
            iter_cap_reg     <= mbe_pkg::RST_ITER_CAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (mbe_pkg::cfg_index_t'(cfg_index))
                mbe_pkg::CFG_OFFSET_X:     offset_x_reg     <= cfg_data;
                mbe_pkg::CFG_OFFSET_Y:     offset_y_reg     <= cfg_data;
                mbe_pkg::CFG_ZOOM:         zoom_reg         <= cfg_data[mbe_pkg::ZOOM_W-1:0];
                mbe_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[mbe_pkg::DIM_W-1:0];
                mbe_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[mbe_pkg::DIM_W-1:0];
                mbe_pkg::CFG_ITER_CAP:     iter_cap_reg     <= cfg_data[mbe_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        view.offset_x     = $signed(offset_x_reg);
        view.offset_y     = $signed(offset_y_reg);
        view.zoom         = zoom_reg;
        view.frame_width  = frame_width_reg;
        view.frame_height = frame_height_reg;
    end

    mbe_map u_map (
        .clk         (clk),
        .rst_n       (rst_n),
        .view        (view),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .point_valid (map_valid),
        .point_ready (map_ready),
        .point       (map_point)
    );

    mbe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (map_valid),
        .push_ready (map_ready),
        .push_data  (map_point),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_point)
    );

    mbe_iter u_iter (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (q_valid),
        .pop_ready       (q_ready),
        .point           (q_point),
        .iter_cap        (iter_cap_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count)
    );

endmodule

@@ design/mbe_checker.sv @@
// ----------------------------------------------------------------------------
// mbe_checker: port-level checks for the escape-time block
// tracks transactions in flight and checks output hold, capacity and reset
// ----------------------------------------------------------------------------
module mbe_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [mbe_pkg::COUNT_W-1:0]   iteration_count
);

    localparam int FLIGHT_W = $clog2(mbe_pkg::MAX_IN_FLIGHT + 1);

    logic [FLIGHT_W-1:0] flight_reg;
    logic                in_acc;
    logic                out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            flight_reg <= flight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            flight_reg <= flight_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(iteration_count))
        else $error("result changed or dropped while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown during reset");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flight_reg != '0)
        else $error("result with no transaction in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= FLIGHT_W'(mbe_pkg::MAX_IN_FLIGHT))
        else $error("more transactions in flight than the block can hold");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .iteration_count (iteration_count)
);

@@ tb/sv/mandelbrot_escape_time_test.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_test: self-checking bench for the escape-time block
// drives pixel coordinates and view registers over valid/ready channels,
// predicts the iteration counts with a fixed-point model of its own or known values and
// checks the counts in order, under random idling and a long output stall
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mbe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int NUM_PHASES      = 8;
    localparam int PIXELS_PER_PHASE = 86;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef enum int {
        VIEW_NEAR_SET,
        VIEW_DEEP,
        VIEW_WILD
    } view_mode_t;

    typedef struct packed {
        logic                  is_write;
        logic                  known;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [IDX_W-1:0]      px;
        logic [IDX_W-1:0]      py;
        logic [COUNT_W-1:0]    count;
    } step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [IDX_W-1:0]      pixel_x;
    logic [IDX_W-1:0]      pixel_y;
    logic                  out_valid;
    logic                  out_ready;
    logic [COUNT_W-1:0]    iteration_count;

    // view as the block should hold it
    longint view_offset_x;
    longint view_offset_y;
    longint view_zoom;
    longint view_width;
    longint view_height;
    longint iter_limit;

    logic [COUNT_W-1:0] pending_counts[$];
    int     mismatch_count = 0;
    longint cycle_count = 0;
    bit     quiet;
    bit     hold_request;
    int     idle_odds;

    mandelbrot_escape_time dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [COUNT_W-1:0] escape_count(input logic [IDX_W-1:0] x,
                                                        input logic [IDX_W-1:0] y);
        longint two;
        longint four;
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint r2;
        longint i2;
        longint prod;
        longint cross_term;
        longint cnt;
        bit     escaped;
        two   = longint'(2) <<< FRAC_BITS;
        four  = longint'(4) <<< FRAC_BITS;
        cr    = view_offset_x - ((view_width * view_zoom) >>> 1) + longint'(x) * view_zoom;
        ci    = view_offset_y - ((view_height * view_zoom) >>> 1) + longint'(y) * view_zoom;
        zr    = cr;
        zi    = ci;
        cnt   = 0;
        escaped = 1'b0;
        while (cnt < iter_limit && !escaped)
        begin
            // large component escapes before any product is formed
            if (zr >= two || zr <= -two || zi >= two || zi <= -two)
                escaped = 1'b1;
            else
            begin
                r2 = (zr * zr) >>> FRAC_BITS;
                i2 = (zi * zi) >>> FRAC_BITS;
                if (r2 + i2 >= four)
                    escaped = 1'b1;
                else
                begin
                    cnt++;
                    prod  = zr * zi;
                    cross_term = (prod < 0) ? -((-prod) >>> (FRAC_BITS - 1))
                                            : (prod >>> (FRAC_BITS - 1));
                    zr = r2 - i2 + cr;
                    zi = cross_term + ci;
                end
            end
        end
        return COUNT_W'(cnt);
    endfunction

    function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s = '0;
        s.is_write  = 1'b1;
        s.reg_index = idx;
        s.reg_data  = data;
        return s;
    endfunction

    function automatic step_t pixel_step(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
                                         input logic known, input logic [COUNT_W-1:0] count);
        step_t s;
        s = '0;
        s.px    = x;
        s.py    = y;
        s.known = known;
        s.count = count;
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_count(input logic [COUNT_W-1:0] got);
        logic [COUNT_W-1:0] want;
        if (pending_counts.size() == 0)
            report_mismatch($sformatf("iteration_count %0d with no pixel pending", got));
        else
        begin
            want = pending_counts.pop_front();
            if (got !== want)
                report_mismatch($sformatf("iteration_count %0d, expected %0d", got, want));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OFFSET_X:     view_offset_x = longint'($signed(data));
            CFG_OFFSET_Y:     view_offset_y = longint'($signed(data));
            CFG_ZOOM:         view_zoom     = longint'(data[ZOOM_W-1:0]);
            CFG_FRAME_WIDTH:  view_width    = longint'(data[DIM_W-1:0]);
            CFG_FRAME_HEIGHT: view_height   = longint'(data[DIM_W-1:0]);
            CFG_ITER_CAP:     iter_limit    = longint'(data[COUNT_W-1:0]);
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
                              input logic known, input logic [COUNT_W-1:0] count);
        in_valid <= 1'b1;
        pixel_x  <= x;
        pixel_y  <= y;
        do @(posedge clk); while (!in_ready);
        pending_counts.push_back(known ? count : escape_count(x, y));
    endtask

    task automatic maybe_pause();
        if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_view(input view_mode_t mode);
        logic [31:0] span;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] z;
        if (mode == VIEW_WILD)
        begin
            write_reg(CFG_OFFSET_X, $urandom);
            write_reg(CFG_OFFSET_Y, $urandom);
            write_reg(CFG_ZOOM, $urandom);
            write_reg(CFG_FRAME_WIDTH, $urandom_range(0, 8191));
            write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, 8191));
            write_reg(CFG_ITER_CAP, $urandom_range(0, 64));
        end
        else
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(4, 400);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(4, 400);
            span = $urandom_range(32'd1 << 20, 32'd3 << 28);
            z = span / w;
            if (z == 0)
                z = 1;
            write_reg(CFG_OFFSET_X, $urandom_range(0, 32'd3 << 28) - (32'd2 << 28));
            write_reg(CFG_OFFSET_Y, $urandom_range(0, 32'd3 << 28) - (32'd3 << 27));
            write_reg(CFG_ZOOM, z);
            write_reg(CFG_FRAME_WIDTH, w);
            write_reg(CFG_FRAME_HEIGHT, h);
            write_reg(CFG_ITER_CAP, (mode == VIEW_DEEP) ? $urandom_range(100, 255)
                                                        : $urandom_range(1, 64));
        end
    endtask

    // output side: checks each transaction, stalls in bursts, one long hold-off
    initial
    begin : result_side
        int hold_left;
        int stall_left;
        logic ready_next;
        hold_left  = 0;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_count(iteration_count);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            out_ready <= ready_next;
        end
    end

    initial
    begin : pixel_side
        step_t directed[$];
        step_t s;
        int phase;
        int k;
        int span_x;
        int span_y;
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] y;
        view_mode_t mode;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        pixel_x        = '0;
        pixel_y        = '0;
        quiet          = 1'b0;
        hold_request   = 1'b0;
        idle_odds      = 3;
        view_offset_x  = longint'($signed(RST_OFFSET_X));
        view_offset_y  = longint'($signed(RST_OFFSET_Y));
        view_zoom      = longint'(RST_ZOOM);
        view_width     = longint'(RST_FRAME_WIDTH);
        view_height    = longint'(RST_FRAME_HEIGHT);
        iter_limit     = longint'(RST_ITER_CAP);

        // default view spans -2..2 on both axes
        directed.push_back(pixel_step(12'd512, 12'd512, 1'b1, 16'd256));
        directed.push_back(pixel_step(12'd0, 12'd0, 1'b1, 16'd0));
        directed.push_back(pixel_step(12'd4095, 12'd4095, 1'b1, 16'd0));
        directed.push_back(pixel_step(12'd0, 12'd512, 1'b1, 16'd0));
        directed.push_back(pixel_step(12'd256, 12'd512, 1'b0, '0));
        directed.push_back(pixel_step(12'd768, 12'd640, 1'b0, '0));
        // zero limit
        directed.push_back(reg_step(CFG_ITER_CAP, 32'd0));
        directed.push_back(pixel_step(12'd512, 12'd512, 1'b1, 16'd0));
        // full count width
        directed.push_back(reg_step(CFG_ITER_CAP, 32'hFFFF_FFFF));
        directed.push_back(pixel_step(12'd512, 12'd512, 1'b1, 16'hFFFF));
        directed.push_back(reg_step(CFG_ITER_CAP, 32'd1));
        directed.push_back(pixel_step(12'd512, 12'd512, 1'b1, 16'd1));
        directed.push_back(pixel_step(12'd0, 12'd0, 1'b1, 16'd0));
        // zero zoom pins every pixel to the offset
        directed.push_back(reg_step(CFG_ITER_CAP, 32'd40));
        directed.push_back(reg_step(CFG_ZOOM, 32'd0));
        directed.push_back(reg_step(CFG_OFFSET_X, 32'h8000_0000));
        directed.push_back(pixel_step(12'd100, 12'd200, 1'b1, 16'd0));
        directed.push_back(reg_step(CFG_OFFSET_X, 32'h7FFF_FFFF));
        directed.push_back(pixel_step(12'd100, 12'd200, 1'b1, 16'd0));
        directed.push_back(reg_step(CFG_OFFSET_X, 32'hF800_0000));
        directed.push_back(pixel_step(12'd3000, 12'd7, 1'b1, 16'd40));
        // widest zoom and dimensions
        directed.push_back(reg_step(CFG_OFFSET_X, 32'd0));
        directed.push_back(reg_step(CFG_ZOOM, 32'h7FFF_FFFF));
        directed.push_back(reg_step(CFG_FRAME_WIDTH, 32'd8191));
        directed.push_back(reg_step(CFG_FRAME_HEIGHT, 32'd8191));
        directed.push_back(pixel_step(12'd4095, 12'd0, 1'b1, 16'd0));
        directed.push_back(pixel_step(12'd0, 12'd4095, 1'b1, 16'd0));
        // zero dimensions
        directed.push_back(reg_step(CFG_ZOOM, 32'd1048576));
        directed.push_back(reg_step(CFG_FRAME_WIDTH, 32'd0));
        directed.push_back(reg_step(CFG_FRAME_HEIGHT, 32'd0));
        directed.push_back(reg_step(CFG_OFFSET_X, 32'hE000_0000));
        directed.push_back(pixel_step(12'd256, 12'd0, 1'b0, '0));
        directed.push_back(pixel_step(12'd300, 12'd10, 1'b0, '0));
        // dimensions and zoom of one
        directed.push_back(reg_step(CFG_OFFSET_X, 32'd0));
        directed.push_back(reg_step(CFG_ZOOM, 32'd1));
        directed.push_back(reg_step(CFG_FRAME_WIDTH, 32'd1));
        directed.push_back(reg_step(CFG_FRAME_HEIGHT, 32'd1));
        directed.push_back(pixel_step(12'd4095, 12'd4095, 1'b0, '0));
        // writes past the register list leave the view alone
        directed.push_back(reg_step(CFG_SPARE_6, 32'hFFFF_FFFF));
        directed.push_back(reg_step(CFG_SPARE_7, 32'hFFFF_FFFF));
        directed.push_back(pixel_step(12'd512, 12'd512, 1'b0, '0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            s = directed[i];
            if (s.is_write)
            begin
                drain();
                write_reg(s.reg_index, s.reg_data);
            end
            else
            begin
                maybe_pause();
                send_pixel(s.px, s.py, s.known, s.count);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            mode = (phase == 3) ? VIEW_WILD : (phase == 5) ? VIEW_DEEP : VIEW_NEAR_SET;
            pick_view(mode);
            idle_odds = (phase == 1) ? 0 : $urandom_range(0, 4);
            if (phase == NUM_PHASES - 1)
                quiet = 1'b1;
            if (phase == 1)
                hold_request = 1'b1;
            span_x = (view_width == 0 || view_width > 4096) ? 4096 : int'(view_width);
            span_y = (view_height == 0 || view_height > 4096) ? 4096 : int'(view_height);
            for (k = 0; k < PIXELS_PER_PHASE; k++)
            begin
                x = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, span_x - 1))
                                                : IDX_W'($urandom_range(0, 4095));
                y = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, span_y - 1))
                                                : IDX_W'($urandom_range(0, 4095));
                maybe_pause();
                send_pixel(x, y, 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/mbe_pkg.sv
design/mbe_map.sv
design/mbe_fifo.sv
design/mbe_iter.sv
design/mandelbrot_escape_time.sv
design/mbe_checker.sv
tb/sv/mandelbrot_escape_time_test.sv
